FILE: hdl/rmd_pkg.sv
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared constants, types and the address swizzle for the tiled RLE map
// decoder.
// ----------------------------------------------------------------------------
package rmd_pkg;

  localparam int LOG_MAP_SIDE = 10;
  localparam int ADDR_W       = 2 * LOG_MAP_SIDE;
  localparam int POS_W        = ADDR_W + 1;
  localparam int COUNT_W      = 6;
  localparam int BYTE_W       = 8;
  localparam int TILE_BITS    = 3;

  localparam logic [BYTE_W-1:0] RUN_BASE = 8'd192;
  localparam logic [POS_W-1:0]  MAP_TOTAL = POS_W'(1) << ADDR_W;
  localparam logic [POS_W-1:0]  MAP_LAST  = MAP_TOTAL - POS_W'(1);
  localparam logic [ADDR_W-1:0] SIDE_MASK = (ADDR_W'(1) << LOG_MAP_SIDE) - ADDR_W'(1);
  localparam logic [ADDR_W-1:0] TILE_MASK = (ADDR_W'(1) << TILE_BITS) - ADDR_W'(1);
  localparam logic [ADDR_W-1:0] GROUP_MASK =
    ~((ADDR_W'(1) << (LOG_MAP_SIDE + TILE_BITS)) - ADDR_W'(1));

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic emit;     // next pixel of a run goes out this cycle
  } rmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;   // output register can take a pixel
    logic emit_now;    // the offered item yields a pixel
    logic first_last;  // that pixel is the only one
    logic run_last;    // pending run pixel is the last one
  } rmd_status_t;

  function automatic logic [ADDR_W-1:0] swizzle(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] a;
    a = ((p >> LOG_MAP_SIDE) & TILE_MASK)
      | ((p & SIDE_MASK) << TILE_BITS)
      | (p & GROUP_MASK);
    return a;
  endfunction

endpackage

FILE: hdl/rmd_ctrl.sv
// ----------------------------------------------------------------------------
// rmd_ctrl
// Controller: takes input transactions when the output register is free and
// steps through the remaining pixels of a run.
// ----------------------------------------------------------------------------
module rmd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rmd_pkg::rmd_status_t st,
  output rmd_pkg::rmd_cmd_t    cmd
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t state;

  assign in_ready   = (state == IDLE) && st.slot_free;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.emit   = (state == RUN) && st.slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.accept && st.emit_now && !st.first_last) state <= RUN;
        end
        RUN: begin
          if (cmd.emit && st.run_last) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/rmd_datapath.sv
// ----------------------------------------------------------------------------
// rmd_datapath
// Datapath: decode state, map position, run counter and the output register.
// ----------------------------------------------------------------------------
module rmd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rmd_pkg::rmd_cmd_t                 cmd,
  output rmd_pkg::rmd_status_t              st,
  input  logic [rmd_pkg::BYTE_W-1:0]        data_byte,
  input  logic                              restart,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rmd_pkg::ADDR_W-1:0]        pixel_address,
  output logic [rmd_pkg::BYTE_W-1:0]        pixel_value,
  output logic                              run_last,
  output logic                              map_done
);

  logic                          invert;
  logic [rmd_pkg::POS_W-1:0]     position;
  logic [rmd_pkg::COUNT_W-1:0]   pend_count;
  logic                          awaiting;
  logic [rmd_pkg::COUNT_W-1:0]   remain;
  logic [rmd_pkg::BYTE_W-1:0]    value;

  logic                          map_full;
  logic                          at_end;
  logic                          is_header;
  logic [rmd_pkg::COUNT_W-1:0]   first_count;
  logic [rmd_pkg::BYTE_W-1:0]    in_value;
  logic                          pix_fire;
  logic                          pix_last;

  assign map_full    = position[rmd_pkg::POS_W-1];
  assign at_end      = (position == rmd_pkg::MAP_LAST);
  assign is_header   = (data_byte >= rmd_pkg::RUN_BASE);
  assign first_count = awaiting ? pend_count : rmd_pkg::COUNT_W'(1);
  assign in_value    = invert ? ~data_byte : data_byte;

  assign st.slot_free  = !out_valid || out_ready;
  assign st.emit_now   = !restart && !map_full && (awaiting ? (pend_count != '0) : !is_header);
  assign st.first_last = (first_count == rmd_pkg::COUNT_W'(1)) || at_end;
  assign st.run_last   = (remain == rmd_pkg::COUNT_W'(1)) || at_end;

  assign pix_fire = (cmd.accept && st.emit_now) || cmd.emit;
  assign pix_last = cmd.accept ? st.first_last : st.run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert     <= 1'b0;
      position   <= '0;
      pend_count <= '0;
      awaiting   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) invert <= cfg_wr_data;

      if (cmd.accept) begin
        if (!restart && !map_full && !awaiting && is_header) begin
          pend_count <= rmd_pkg::COUNT_W'(data_byte - rmd_pkg::RUN_BASE);
          awaiting   <= 1'b1;
        end else begin
          // restart, full map, run value or literal: nothing stays pending
          pend_count <= '0;
          awaiting   <= 1'b0;
        end
      end

      if (cmd.accept && restart) begin
        position <= '0;
      end else if (pix_fire) begin
        position <= position + rmd_pkg::POS_W'(1);
      end

      if (pix_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      pixel_address <= rmd_pkg::swizzle(position[rmd_pkg::ADDR_W-1:0]);
      pixel_value   <= cmd.accept ? in_value : value;
      run_last      <= pix_last;
      map_done      <= at_end;
      remain        <= (cmd.accept ? first_count : remain) - rmd_pkg::COUNT_W'(1);
    end
    if (cmd.accept) value <= in_value;
  end

endmodule

FILE: hdl/rle_map_decoder_tiled.sv
// A pixel appears on the output register in the cycle after its byte is taken.
// Throughput: one literal byte per cycle unless the output stalls; a run value
// byte of count N holds off input after it is taken while the run counter steps
// out the rest. Run headers, ignored bytes and restarts give no pixel.
// Reset (synchronous, rst high) clears position, run state and the invert flag.
// ----------------------------------------------------------------------------
// rle_map_decoder_tiled
// PCX-style run-length decoder writing a 1024 x 1024 byte map with swizzled
// store addresses; runs are clipped at the end of the map.
// ----------------------------------------------------------------------------
module rle_map_decoder_tiled (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rmd_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rmd_pkg::ADDR_W-1:0]  pixel_address,
  output logic [rmd_pkg::BYTE_W-1:0]  pixel_value,
  output logic                        run_last,
  output logic                        map_done
);

  rmd_pkg::rmd_cmd_t    cmd;
  rmd_pkg::rmd_status_t st;

  rmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rmd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .data_byte     (data_byte),
    .restart       (restart),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .run_last      (run_last),
    .map_done      (map_done)
  );

  // Never take input while a run is still being stepped out.
  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !cmd.accept)
    else $error("input taken during run");

  // The final map pixel always closes its transaction's pixels.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && map_done) |-> run_last)
    else $error("map_done without run_last");

  // The final map position swizzles to the top address.
  a_done_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && map_done) |-> (pixel_address == '1))
    else $error("map_done at wrong address");

  // Input is only taken when the output register can absorb a pixel.
  a_ready_slot: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> st.slot_free)
    else $error("ready with output blocked");

endmodule
